/* src/additive_triangle_oscillator_defines.svh */
// assertion macros for the additive triangle oscillator
`ifndef ADDITIVE_TRIANGLE_OSCILLATOR_DEFINES_SVH
`define ADDITIVE_TRIANGLE_OSCILLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define ATO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ATO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATO_ASSERT(lbl, prop, msg)
`define ATO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/ato_pkg.sv */
// shared types and constants for the additive triangle oscillator
package ato_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_HARMONIC_DEF    = 15;
  localparam int unsigned COS_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned SAMPLE_BITS_DEF     = 24;

  // field and register widths
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned AMP_W     = 23;
  localparam int unsigned HH_W      = 4;
  localparam int unsigned DC_W      = 24;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam logic [PHASE_W-1:0]      STEP_RST = 32'd24347887;
  localparam logic [AMP_W-1:0]        AMP_RST  = 23'd2097152;
  localparam logic [HH_W-1:0]         HH_RST   = 4'd15;
  localparam logic signed [DC_W-1:0]  DC_RST   = 24'sd2097152;

  // fixed-point formats
  localparam int unsigned FIX_FRAC = 28;
  localparam int unsigned MAG_W    = FIX_FRAC + 1;  // cosine magnitude, 0 .. 1.0 in Q28
  localparam int unsigned QUO_W    = 24;            // rounded amplitude*|cos| before the h*h divide
  localparam int unsigned RECIP_W  = QUO_W + 2;     // reciprocal of h*h
  localparam int unsigned MUL_W    = MAG_W;         // operand width of the shared multiplier
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned SH_W     = 6;             // reciprocal shift, 32 for harmonic 15

  localparam longint          FIX_ONE     = longint'(1) << FIX_FRAC;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_HIGHEST    = 2'd2,
    REG_DC_OFFSET  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_AMP,
    ST_RND,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_div;
    logic rnd;
    logic acc;
    logic fin;
  } seq_t;

  // datapath to sequencer
  typedef struct packed {
    logic any_term;
    logic more;
    logic out_free;
  } stat_t;

endpackage

/* src/ato_mul.sv */
// shared multiplier with registered product
module ato_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ato_pkg::MUL_W-1:0]    a_i,
  input  logic [ato_pkg::MUL_W-1:0]    b_i,
  output logic [ato_pkg::PROD_W-1:0]   p_o
);

  logic [ato_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ato_pkg::PROD_W'(a_i) * ato_pkg::PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

/* src/ato_cos_rom.sv */
// quarter-wave cosine table, registered read
module ato_cos_rom #(
  parameter int unsigned COS_TABLE_DEPTH = ato_pkg::COS_TABLE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0]   addr_i,
  output logic [ato_pkg::MAG_W-1:0]              data_o
);

  localparam longint ONE = ato_pkg::FIX_ONE;

  logic [ato_pkg::MAG_W-1:0] tab [COS_TABLE_DEPTH+1];
  logic [ato_pkg::MAG_W-1:0] data_q;

  for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_tab
    // angle of entry gi in Q30, pi/2 spread over the table
    localparam longint unsigned XV =
      (longint'(gi) * ato_pkg::HALF_PI_Q30) / COS_TABLE_DEPTH;
    // taylor series in Q28, innermost term first, each quotient truncated
    localparam longint Y  = longint'((XV * XV) >> 32);
    localparam longint R7 = ONE - (Y * ONE) / (longint'(13 * 14) * ONE);
    localparam longint R6 = ONE - (Y * R7) / (longint'(11 * 12) * ONE);
    localparam longint R5 = ONE - (Y * R6) / (longint'(9 * 10) * ONE);
    localparam longint R4 = ONE - (Y * R5) / (longint'(7 * 8) * ONE);
    localparam longint R3 = ONE - (Y * R4) / (longint'(5 * 6) * ONE);
    localparam longint R2 = ONE - (Y * R3) / (longint'(3 * 4) * ONE);
    localparam longint R1 = ONE - (Y * R2) / (longint'(1 * 2) * ONE);
    localparam longint RC = (R1 < 0) ? longint'(0) : ((R1 > ONE) ? ONE : R1);
    assign tab[gi] = ato_pkg::MAG_W'(RC);
  end

  always_ff @(posedge clk_i) begin
    data_q <= tab[addr_i];
  end

  assign data_o = data_q;

endmodule

/* src/ato_ctrl.sv */
// sequencer: one pass of look, scale, round, divide, accumulate per odd harmonic
module ato_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ato_pkg::stat_t  stat_i,
  output logic            in_ready_o,
  output ato_pkg::seq_t   seq_o
);

  ato_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ato_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    seq_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ato_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          seq_o.load = 1'b1;
          state_d    = stat_i.any_term ? ato_pkg::ST_LOOK : ato_pkg::ST_FIN;
        end
      end
      ato_pkg::ST_LOOK: begin
        state_d = ato_pkg::ST_AMP;
      end
      ato_pkg::ST_AMP: begin
        seq_o.mul_en = 1'b1;
        state_d      = ato_pkg::ST_RND;
      end
      ato_pkg::ST_RND: begin
        seq_o.rnd = 1'b1;
        state_d   = ato_pkg::ST_DIV;
      end
      ato_pkg::ST_DIV: begin
        seq_o.mul_en  = 1'b1;
        seq_o.mul_div = 1'b1;
        state_d       = ato_pkg::ST_ACC;
      end
      ato_pkg::ST_ACC: begin
        seq_o.acc = 1'b1;
        state_d   = stat_i.more ? ato_pkg::ST_LOOK : ato_pkg::ST_FIN;
      end
      ato_pkg::ST_FIN: begin
        // wait until the output register can take the word
        if (stat_i.out_free) begin
          seq_o.fin = 1'b1;
          state_d   = ato_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ato_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/additive_triangle_oscillator.sv */
// top level: triangle wave from odd cosine harmonics, one shared multiplier
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    restart_i
//   out       output     out_valid_o / out_ready_i  sample_o, clipped_o
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// an item runs from accept through look, scale, round, divide and accumulate for each
// odd harmonic, eight with the default limit of 15, then finishes once the output is free
// each harmonic uses the multiplier twice (amplitude*|cos|, then reciprocal of h*h)
// with a cosine table read before and a rounding add between
// the cosine table is a constant rom, so reset needs no clearing pass
// a finished word waits in the output register; a new word is accepted meanwhile
module additive_triangle_oscillator #(
  parameter int unsigned MAX_HARMONIC    = ato_pkg::MAX_HARMONIC_DEF,
  parameter int unsigned COS_TABLE_DEPTH = ato_pkg::COS_TABLE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS     = ato_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_we_i,
  input  logic [ato_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ato_pkg::CFG_W-1:0]            cfg_data_i
);

  `include "additive_triangle_oscillator_defines.svh"

  localparam int unsigned PHASE_W = ato_pkg::PHASE_W;
  localparam int unsigned AW      = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned IDX_PW  = 30 + AW;
  localparam int unsigned H_W     = $clog2(MAX_HARMONIC + 3);
  localparam int unsigned L_W     = (H_W > ato_pkg::HH_W) ? H_W : ato_pkg::HH_W;
  localparam int unsigned N_ODD   = (MAX_HARMONIC + 1) / 2;
  localparam int unsigned HI_W    = (N_ODD > 1) ? $clog2(N_ODD) : 1;
  localparam int unsigned ACC_W   = (SAMPLE_BITS >= 26) ? SAMPLE_BITS + 1 : 27;
  localparam int unsigned PROD_W  = ato_pkg::PROD_W;
  localparam int unsigned QUO_W   = ato_pkg::QUO_W;

  localparam logic signed [ACC_W-1:0] SMAX =
    signed'({{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX_S = SAMPLE_BITS'(SMAX);
  localparam logic signed [SAMPLE_BITS-1:0] SMIN_S = SAMPLE_BITS'(SMIN);

  // configuration registers
  logic [PHASE_W-1:0]              step_q;
  logic [ato_pkg::AMP_W-1:0]       amp_q;
  logic [ato_pkg::HH_W-1:0]        hh_q;
  logic signed [ato_pkg::DC_W-1:0] dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ato_pkg::STEP_RST;
      amp_q  <= ato_pkg::AMP_RST;
      hh_q   <= ato_pkg::HH_RST;
      dc_q   <= ato_pkg::DC_RST;
    end else if (cfg_we_i) begin
      unique case (ato_pkg::cfg_reg_e'(cfg_idx_i))
        ato_pkg::REG_PHASE_STEP: step_q <= cfg_data_i;
        ato_pkg::REG_AMPLITUDE:  amp_q  <= cfg_data_i[ato_pkg::AMP_W-1:0];
        ato_pkg::REG_HIGHEST:    hh_q   <= cfg_data_i[ato_pkg::HH_W-1:0];
        ato_pkg::REG_DC_OFFSET:  dc_q   <= signed'(cfg_data_i[ato_pkg::DC_W-1:0]);
        default: ;
      endcase
    end
  end

  // per-harmonic constants: reciprocal of h*h, its shift, and half of h*h in Q28
  logic [ato_pkg::RECIP_W-1:0] rcp_tab [N_ODD];
  logic [ato_pkg::SH_W-1:0]    shf_tab [N_ODD];
  logic [PROD_W-1:0]           rnd_tab [N_ODD];

  for (genvar gi = 0; gi < N_ODD; gi++) begin : g_harm
    localparam longint unsigned HN = longint'(2 * gi + 1);
    localparam longint unsigned DV = HN * HN;
    localparam int unsigned     LG = $clog2(DV);
    localparam longint unsigned MV = ((64'd1 << (QUO_W + LG)) + DV - 1) / DV;
    assign rcp_tab[gi] = ato_pkg::RECIP_W'(MV);
    assign shf_tab[gi] = ato_pkg::SH_W'(QUO_W + LG);
    assign rnd_tab[gi] = PROD_W'(DV) << (ato_pkg::FIX_FRAC - 1);
  end

  // sequencer
  ato_pkg::seq_t  seq;
  ato_pkg::stat_t stat;

  ato_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .seq_o      (seq)
  );

  // phase state
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_use;
  logic [PHASE_W-1:0] phase_d;

  assign phase_use = restart_i ? '0 : phase_q;
  assign phase_d   = phase_use + step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (seq.load) begin
      phase_q <= phase_d;
    end
  end

  // harmonic loop registers
  logic [PHASE_W-1:0]      base_q;
  logic [PHASE_W-1:0]      hp_q;
  logic [H_W-1:0]          h_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic [QUO_W-1:0]        q_q;
  logic [QUO_W-1:0]        q_d;

  logic [H_W-1:0]  h_nx;
  logic [L_W-1:0]  hh_ext;
  logic [L_W-1:0]  max_ext;
  logic [L_W-1:0]  limit;
  logic [HI_W-1:0] hi;

  assign hh_ext  = L_W'(hh_q);
  assign max_ext = L_W'(MAX_HARMONIC);
  assign limit   = (hh_ext > max_ext) ? max_ext : hh_ext;
  assign h_nx    = h_q + H_W'(2);
  assign hi      = HI_W'(h_q >> 1);

  // cosine lookup: quadrant from the top bits, odd quadrants read mirrored
  logic [IDX_PW-1:0]          idx_prod;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              rom_addr;
  logic [ato_pkg::MAG_W-1:0]  rom_data;
  logic                       cos_neg;

  assign idx_prod = IDX_PW'(hp_q[29:0]) * IDX_PW'(COS_TABLE_DEPTH);
  assign idx      = idx_prod[IDX_PW-1:30];
  assign rom_addr = hp_q[30] ? (AW'(COS_TABLE_DEPTH) - idx) : idx;
  assign cos_neg  = hp_q[31] ^ hp_q[30];

  ato_cos_rom #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shared multiplier: amplitude*|cos| first, then quotient*reciprocal
  logic [ato_pkg::MUL_W-1:0] mul_a;
  logic [ato_pkg::MUL_W-1:0] mul_b;
  logic [PROD_W-1:0]         prod;

  assign mul_a = seq.mul_div ? ato_pkg::MUL_W'(q_q) : ato_pkg::MUL_W'(amp_q);
  assign mul_b = seq.mul_div ? ato_pkg::MUL_W'(rcp_tab[hi]) : rom_data;

  ato_mul u_mul (
    .clk_i (clk_i),
    .en_i  (seq.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // round to nearest, then the exact divide by h*h through the reciprocal
  logic [PROD_W-1:0]       rnd_sum;
  logic [PROD_W-1:0]       div_full;
  logic [QUO_W-1:0]        term_u;
  logic signed [ACC_W-1:0] term_s;

  assign rnd_sum  = prod + rnd_tab[hi];
  assign q_d      = rnd_sum[ato_pkg::FIX_FRAC +: QUO_W];
  assign div_full = prod >> shf_tab[hi];
  assign term_u   = div_full[QUO_W-1:0];
  assign term_s   = signed'(ACC_W'(term_u));
  assign acc_d    = cos_neg ? (acc_q - term_s) : (acc_q + term_s);

  always_ff @(posedge clk_i) begin
    if (seq.load) begin
      base_q <= phase_use;
      hp_q   <= phase_use;
      h_q    <= H_W'(1);
      acc_q  <= ACC_W'(dc_q);
    end else if (seq.acc) begin
      hp_q  <= hp_q + (base_q << 1);
      h_q   <= h_nx;
      acc_q <= acc_d;
    end
    if (seq.rnd) begin
      q_q <= q_d;
    end
  end

  // saturation and output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] sample_d;
  logic                          clipped_q;
  logic                          clipped_d;

  always_comb begin
    priority if (acc_q > SMAX) begin
      sample_d  = SMAX_S;
      clipped_d = 1'b1;
    end else if (acc_q < SMIN) begin
      sample_d  = SMIN_S;
      clipped_d = 1'b1;
    end else begin
      sample_d  = SAMPLE_BITS'(acc_q);
      clipped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.fin) begin
      sample_q  <= sample_d;
      clipped_q <= clipped_d;
    end
  end

  assign stat.any_term = (limit != '0);
  assign stat.more     = (L_W'(h_nx) <= limit);
  assign stat.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clipped_q;

  // one word in flight: after an accept the block is busy
  `ATO_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  // phase advances by the step, from zero on restart
  `ATO_ASSERT_NEXT(a_phase_advance, in_valid_i && in_ready_o, phase_q == ($past(restart_i) ? $past(step_q) : $past(phase_q) + $past(step_q)), "phase update wrong")
  // a clipped word sits at one of the range ends
  `ATO_ASSERT(a_clip_at_rail, !(out_valid_o && clipped_o) || sample_o == SMAX_S || sample_o == SMIN_S, "clip flag off the rails")

endmodule
